[src/bcp_pkg.sv]
// Shared types, codes and constants for the container header parser.
package bcp_pkg;

  localparam int PALETTE_MAX_DEF = 256;
  localparam int SIZE_BITS_DEF   = 32;
  localparam int FIFO_DEPTH      = 4;

  localparam logic [33:0] POS_MAX     = '1;
  localparam logic [31:0] TAG_PALETTE = 32'h544C_4150;
  localparam logic [31:0] TAG_MASKS   = 32'h4B53_414D;
  localparam logic [5:0]  HEAD_END    = 6'd30;

  localparam logic [1:0] KIND_PALETTE = 2'd0;
  localparam logic [1:0] KIND_MASK    = 2'd1;
  localparam logic [1:0] KIND_STATUS  = 2'd2;

  localparam logic [3:0] ST_OK         = 4'd0;
  localparam logic [3:0] ST_TRUNC      = 4'd1;
  localparam logic [3:0] ST_MAGIC      = 4'd2;
  localparam logic [3:0] ST_VERSION    = 4'd3;
  localparam logic [3:0] ST_ZERO_SIZE  = 4'd4;
  localparam logic [3:0] ST_DEPTH      = 4'd5;
  localparam logic [3:0] ST_ENCODING   = 4'd6;
  localparam logic [3:0] ST_FORMAT     = 4'd7;
  localparam logic [3:0] ST_OVERFLOW   = 4'd8;
  localparam logic [3:0] ST_PAL_BIG    = 4'd9;
  localparam logic [3:0] ST_NO_PALETTE = 4'd10;
  localparam logic [3:0] ST_NO_MASKS   = 4'd11;

  typedef enum logic [2:0] {
    CFG_MAGIC   = 3'd0,
    CFG_VERSION = 3'd1,
    CFG_ENC_LIM = 3'd2,
    CFG_FMT_LIM = 3'd3,
    CFG_CUSTOM  = 3'd4,
    CFG_PAL_BIT = 3'd5,
    CFG_MSK_BIT = 3'd6
  } cfg_idx_t;

  typedef enum logic [2:0] {
    PH_HEAD   = 3'd0,
    PH_PCOUNT = 3'd1,
    PH_PENTRY = 3'd2,
    PH_MWORD  = 3'd3,
    PH_SKIP   = 3'd4
  } phase_t;

  typedef struct packed {
    logic [31:0] magic_word;
    logic [15:0] required_version;
    logic [7:0]  encoding_limit;
    logic [7:0]  format_limit;
    logic [7:0]  custom_format_code;
    logic [7:0]  palette_flag_bit;
    logic [7:0]  masks_flag_bit;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  index;
    logic [31:0] value;
    logic [3:0]  status;
    logic [15:0] width;
    logic [15:0] height;
    logic [7:0]  depth;
    logic [7:0]  encoding;
    logic [7:0]  format;
    logic [8:0]  pal_size;
    logic        last;
  } rec_t;

endpackage

[src/bcp_fifo.sv]
// Small record queue: up to two pushes and one pop per cycle.
module bcp_fifo #(
  parameter int DEPTH = bcp_pkg::FIFO_DEPTH
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic [1:0]     push_n,
  input  bcp_pkg::rec_t  push_d0,
  input  bcp_pkg::rec_t  push_d1,
  input  logic           pop,
  output bcp_pkg::rec_t  head,
  output logic           not_empty,
  output logic           room2
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  bcp_pkg::rec_t    mem_r [DEPTH];
  logic [AW-1:0]    wp_r, rp_r;
  logic [CW-1:0]    cnt_r;
  logic [AW-1:0]    wp1;

  assign wp1       = wp_r + AW'(1);
  assign head      = mem_r[rp_r];
  assign not_empty = cnt_r != '0;
  assign room2     = cnt_r <= CW'(DEPTH - 2);

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) mem_r[wp_r] <= push_d0;
    if (push_n == 2'd2) mem_r[wp1] <= push_d1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_r + AW'(push_n);
      if (pop) rp_r <= rp_r + AW'(1);
      cnt_r <= cnt_r + CW'(push_n) - CW'(pop);
    end
  end

endmodule

[src/bcp_core.sv]
// Byte-at-a-time parse state: magic, header, section bounds and chunk walker.
module bcp_core #(
  parameter int PALETTE_MAX = bcp_pkg::PALETTE_MAX_DEF,
  parameter int SIZE_BITS   = bcp_pkg::SIZE_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           take,
  input  logic [7:0]     file_byte,
  input  logic           end_of_file,
  input  bcp_pkg::cfg_t  cfg,
  output logic [1:0]     rec_n,
  output bcp_pkg::rec_t  rec0,
  output bcp_pkg::rec_t  rec1
);

  localparam logic [34:0] LIM = (35'(1) << SIZE_BITS) - 35'(1);

  logic [33:0] pos_r, pos_nxt;
  logic [31:0] magic_r, magic_nxt;
  logic [15:0] ver_r, ver_nxt, wid_r, wid_nxt, hgt_r, hgt_nxt;
  logic [7:0]  dep_r, dep_nxt, enc_r, enc_nxt, fmt_r, fmt_nxt, flg_r, flg_nxt;
  logic [31:0] sz0_r, sz0_nxt, sz1_r, sz1_nxt, sz2_r, sz2_nxt;
  logic [34:0] acc_r, acc_nxt, xs_r, xs_nxt, xe_r, xe_nxt, me_r, me_nxt;
  logic        ov_r, ov_nxt;
  bcp_pkg::phase_t phase_r, phase_nxt;
  logic [2:0]  sub_r, sub_nxt;
  logic [31:0] tag_r, tag_nxt, remn_r, remn_nxt, gat_r, gat_nxt;
  logic [8:0]  cnt_r, cnt_nxt, palc_r, palc_nxt;
  logic        seenp_r, seenp_nxt, seenm_r, seenm_nxt;
  logic [3:0]  err_r, err_nxt;

  logic [3:0]  hchk;
  logic        dep_ok;
  logic [34:0] pos_x, rem, sum_a, sum_b;
  logic        in_extra, word_done, brk;
  logic [31:0] rm, w;
  logic        emit;
  logic [1:0]  emit_kind;
  logic [7:0]  emit_idx;
  logic [34:0] flen;
  logic [3:0]  st;
  logic        hok, pok;
  bcp_pkg::rec_t item, fin;

  assign pos_x    = {1'b0, pos_r};
  assign rem      = xe_r - pos_x;
  assign in_extra = (pos_x >= xs_r) && (pos_x < xe_r);

  // header checks, ordered by precedence
  always_comb begin
    case (dep_r) inside
      8'd1, 8'd2, 8'd4, 8'd8, 8'd16, 8'd24, 8'd32: dep_ok = 1'b1;
      default: dep_ok = 1'b0;
    endcase
    if (ver_r != cfg.required_version) hchk = bcp_pkg::ST_VERSION;
    else if (wid_r == '0 || hgt_r == '0) hchk = bcp_pkg::ST_ZERO_SIZE;
    else if (!dep_ok) hchk = bcp_pkg::ST_DEPTH;
    else if (enc_r >= cfg.encoding_limit) hchk = bcp_pkg::ST_ENCODING;
    else if (fmt_r >= cfg.format_limit) hchk = bcp_pkg::ST_FORMAT;
    else if (fmt_r <= 8'd3 && dep_r != (8'd1 << fmt_r[1:0])) hchk = bcp_pkg::ST_DEPTH;
    else if (ov_r) hchk = bcp_pkg::ST_OVERFLOW;
    else hchk = bcp_pkg::ST_OK;
  end

  // next state
  always_comb begin
    magic_nxt = magic_r; ver_nxt = ver_r; wid_nxt = wid_r; hgt_nxt = hgt_r;
    dep_nxt = dep_r; enc_nxt = enc_r; fmt_nxt = fmt_r; flg_nxt = flg_r;
    sz0_nxt = sz0_r; sz1_nxt = sz1_r; sz2_nxt = sz2_r;
    acc_nxt = acc_r; xs_nxt = xs_r; xe_nxt = xe_r; me_nxt = me_r; ov_nxt = ov_r;
    phase_nxt = phase_r; sub_nxt = sub_r; tag_nxt = tag_r; remn_nxt = remn_r;
    gat_nxt = gat_r; cnt_nxt = cnt_r; palc_nxt = palc_r;
    seenp_nxt = seenp_r; seenm_nxt = seenm_r; err_nxt = err_r;
    sum_a = '0; sum_b = '0; rm = remn_r; w = '0; word_done = 1'b0; brk = 1'b0;
    emit = 1'b0; emit_kind = bcp_pkg::KIND_PALETTE; emit_idx = cnt_r[7:0];
    pos_nxt = (pos_r == bcp_pkg::POS_MAX) ? pos_r : pos_r + 34'd1;

    if (pos_r < 34'd4) begin
      magic_nxt[8*pos_r[1:0] +: 8] = file_byte;
      if (pos_r == 34'd3 && magic_nxt != cfg.magic_word) err_nxt = bcp_pkg::ST_MAGIC;
    end else if (pos_r < 34'(bcp_pkg::HEAD_END)) begin
      case (pos_r[4:0])
        5'd4:  ver_nxt[7:0]   = file_byte;
        5'd5:  ver_nxt[15:8]  = file_byte;
        5'd6:  wid_nxt[7:0]   = file_byte;
        5'd7:  wid_nxt[15:8]  = file_byte;
        5'd8:  hgt_nxt[7:0]   = file_byte;
        5'd9:  hgt_nxt[15:8]  = file_byte;
        5'd10: dep_nxt        = file_byte;
        5'd11: enc_nxt        = file_byte;
        5'd12: fmt_nxt        = file_byte;
        5'd13: flg_nxt        = file_byte;
        5'd14: sz0_nxt[7:0]   = file_byte;
        5'd15: sz0_nxt[15:8]  = file_byte;
        5'd16: sz0_nxt[23:16] = file_byte;
        5'd17: sz0_nxt[31:24] = file_byte;
        5'd18: sz1_nxt[7:0]   = file_byte;
        5'd19: sz1_nxt[15:8]  = file_byte;
        5'd20: sz1_nxt[23:16] = file_byte;
        5'd21: sz1_nxt[31:24] = file_byte;
        5'd22: sz2_nxt[7:0]   = file_byte;
        5'd23: sz2_nxt[15:8]  = file_byte;
        5'd24: sz2_nxt[23:16] = file_byte;
        5'd25: sz2_nxt[31:24] = file_byte;
        // reserved word: section bounds are summed one size per byte
        5'd26: begin
          sum_a   = 35'(bcp_pkg::HEAD_END) + {3'b0, sz0_r};
          xs_nxt  = sum_a;
          ov_nxt  = sum_a > LIM;
          acc_nxt = (sum_a > LIM) ? '0 : sum_a;
        end
        5'd27: begin
          xe_nxt  = xs_r + {3'b0, sz1_r};
          sum_b   = acc_r + {3'b0, sz1_r};
          ov_nxt  = ov_r | (sum_b > LIM);
          acc_nxt = (sum_b > LIM) ? '0 : sum_b;
        end
        5'd28: begin
          me_nxt  = xe_r + {3'b0, sz2_r};
          sum_b   = acc_r + {3'b0, sz2_r};
          ov_nxt  = ov_r | (sum_b > LIM);
        end
        default: ;
      endcase
      if (pos_r == 34'd29 && err_r == bcp_pkg::ST_OK) err_nxt = hchk;
    end else if (err_r == bcp_pkg::ST_OK && in_extra) begin
      if (phase_r == bcp_pkg::PH_HEAD) begin
        if (sub_r == 3'd0 && rem < 35'd8) begin
          err_nxt = bcp_pkg::ST_TRUNC;
        end else begin
          if (!sub_r[2]) tag_nxt[8*sub_r[1:0] +: 8] = file_byte;
          else gat_nxt[8*sub_r[1:0] +: 8] = file_byte;
          if (sub_r == 3'd7) begin
            sub_nxt = 3'd0;
            if ({3'b0, gat_nxt} > rem - 35'd1) begin
              err_nxt = bcp_pkg::ST_TRUNC;
            end else begin
              remn_nxt = gat_nxt;
              if (tag_r == bcp_pkg::TAG_PALETTE) begin
                if (gat_nxt < 32'd4) err_nxt = bcp_pkg::ST_TRUNC;
                else phase_nxt = bcp_pkg::PH_PCOUNT;
              end else if (tag_r == bcp_pkg::TAG_MASKS) begin
                if (gat_nxt < 32'd16) err_nxt = bcp_pkg::ST_TRUNC;
                else begin
                  phase_nxt = bcp_pkg::PH_MWORD;
                  cnt_nxt   = '0;
                end
              end else if (gat_nxt != '0) begin
                phase_nxt = bcp_pkg::PH_SKIP;
              end
            end
          end else begin
            sub_nxt = sub_r + 3'd1;
          end
        end
      end else begin
        rm       = remn_r - 32'(remn_r != '0);
        remn_nxt = rm;
        if (phase_r != bcp_pkg::PH_SKIP) begin
          gat_nxt[8*sub_r[1:0] +: 8] = file_byte;
          word_done = sub_r[1:0] == 2'd3;
          sub_nxt   = word_done ? 3'd0 : sub_r + 3'd1;
        end
        w = gat_nxt;
        if (word_done) begin
          unique case (phase_r)
            bcp_pkg::PH_PCOUNT: begin
              if (w > 32'(PALETTE_MAX)) begin
                err_nxt = bcp_pkg::ST_PAL_BIG;
                brk     = 1'b1;
              end else if ({w, 2'b00} > {2'b00, rm}) begin
                err_nxt = bcp_pkg::ST_TRUNC;
                brk     = 1'b1;
              end else begin
                palc_nxt  = w[8:0];
                seenp_nxt = 1'b1;
                cnt_nxt   = '0;
                phase_nxt = (w != '0) ? bcp_pkg::PH_PENTRY : bcp_pkg::PH_SKIP;
              end
            end
            bcp_pkg::PH_PENTRY: begin
              emit      = 1'b1;
              emit_kind = bcp_pkg::KIND_PALETTE;
              cnt_nxt   = cnt_r + 9'd1;
              if (cnt_nxt >= palc_r) phase_nxt = bcp_pkg::PH_SKIP;
            end
            bcp_pkg::PH_MWORD: begin
              emit      = 1'b1;
              emit_kind = bcp_pkg::KIND_MASK;
              cnt_nxt   = cnt_r + 9'd1;
              if (cnt_nxt >= 9'd4) begin
                seenm_nxt = 1'b1;
                phase_nxt = bcp_pkg::PH_SKIP;
              end
            end
            default: ;
          endcase
        end
        if (!brk && rm == '0) begin
          phase_nxt = bcp_pkg::PH_HEAD;
          sub_nxt   = 3'd0;
        end
      end
    end
  end

  // records: chunk entry and final status
  always_comb begin
    flen = pos_x + 35'd1;
    hok  = 1'b0;
    pok  = 1'b0;
    if (flen < 35'(bcp_pkg::HEAD_END)) begin
      st = bcp_pkg::ST_TRUNC;
    end else if (err_nxt >= bcp_pkg::ST_MAGIC && err_nxt <= bcp_pkg::ST_OVERFLOW) begin
      st  = err_nxt;
      hok = err_nxt != bcp_pkg::ST_MAGIC;
    end else begin
      hok = 1'b1;
      if (flen < me_r) begin
        st = bcp_pkg::ST_TRUNC;
      end else begin
        pok = 1'b1;
        if (err_nxt != bcp_pkg::ST_OK) st = err_nxt;
        else if ((flg_r & cfg.palette_flag_bit) != '0 && !seenp_nxt)
          st = bcp_pkg::ST_NO_PALETTE;
        else if ((flg_r & cfg.masks_flag_bit) != '0 && !seenm_nxt)
          st = bcp_pkg::ST_NO_MASKS;
        else if (fmt_r <= 8'd3 && !seenp_nxt) st = bcp_pkg::ST_NO_PALETTE;
        else if (fmt_r == cfg.custom_format_code && !seenm_nxt) st = bcp_pkg::ST_NO_MASKS;
        else st = bcp_pkg::ST_OK;
      end
    end

    fin          = '0;
    fin.kind     = bcp_pkg::KIND_STATUS;
    fin.status   = st;
    fin.last     = 1'b1;
    if (hok) begin
      fin.width    = wid_r;
      fin.height   = hgt_r;
      fin.depth    = dep_r;
      fin.encoding = enc_r;
      fin.format   = fmt_r;
    end
    if (pok) fin.pal_size = palc_nxt;

    item       = '0;
    item.kind  = emit_kind;
    item.index = emit_idx;
    item.value = w;
    item.last  = !end_of_file;

    rec0  = emit ? item : fin;
    rec1  = fin;
    rec_n = take ? (2'(emit) + 2'(end_of_file)) : 2'd0;
  end

  // payload: lane-written, every lane is written before it is read
  always_ff @(posedge clk) begin
    if (take) begin
      magic_r <= magic_nxt; ver_r <= ver_nxt; wid_r <= wid_nxt; hgt_r <= hgt_nxt;
      dep_r <= dep_nxt; enc_r <= enc_nxt; fmt_r <= fmt_nxt; flg_r <= flg_nxt;
      sz0_r <= sz0_nxt; sz1_r <= sz1_nxt; sz2_r <= sz2_nxt;
      acc_r <= acc_nxt; xs_r <= xs_nxt; xe_r <= xe_nxt; me_r <= me_nxt;
      tag_r <= tag_nxt; remn_r <= remn_nxt; gat_r <= gat_nxt;
    end
  end

  // control: cleared by reset and by the last byte of a file
  always_ff @(posedge clk) begin
    if (!rst_n || (take && end_of_file)) begin
      pos_r   <= '0;
      ov_r    <= 1'b0;
      phase_r <= bcp_pkg::PH_HEAD;
      sub_r   <= '0;
      cnt_r   <= '0;
      palc_r  <= '0;
      seenp_r <= 1'b0;
      seenm_r <= 1'b0;
      err_r   <= bcp_pkg::ST_OK;
    end else if (take) begin
      pos_r   <= pos_nxt;
      ov_r    <= ov_nxt;
      phase_r <= phase_nxt;
      sub_r   <= sub_nxt;
      cnt_r   <= cnt_nxt;
      palc_r  <= palc_nxt;
      seenp_r <= seenp_nxt;
      seenm_r <= seenm_nxt;
      err_r   <= err_nxt;
    end
  end

endmodule

[src/bitmap_container_header_parser.sv]
// Top level: configuration registers, parse core and output record queue.
// One file byte is taken per cycle whenever the output queue has room for two
// records, so the sustained rate is one byte per clock while results drain; a
// byte yields up to two records (a palette or mask entry and the final status)
// that leave one per cycle, while out_ready is high, from a four-entry queue
// in which each result is registered. Section bounds are summed during the
// reserved header word, one add per byte, so header checking needs
// no wide add chain. Configuration is written through cfg_we/cfg_index/cfg_data
// and takes effect at the next check that uses it.
module bitmap_container_header_parser #(
  parameter int PALETTE_MAX = bcp_pkg::PALETTE_MAX_DEF,
  parameter int SIZE_BITS   = bcp_pkg::SIZE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_file_byte,
  input  logic        in_end_of_file,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_record_kind,
  output logic [7:0]  out_record_index,
  output logic [31:0] out_record_value,
  output logic [3:0]  out_status_code,
  output logic [15:0] out_image_width,
  output logic [15:0] out_image_height,
  output logic [7:0]  out_depth_bits,
  output logic [7:0]  out_encoding_mode,
  output logic [7:0]  out_format_code,
  output logic [8:0]  out_palette_size,
  output logic        out_run_last,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  bcp_pkg::cfg_t cfg_r;
  bcp_pkg::rec_t rec0, rec1, head;
  logic [1:0]    rec_n;
  logic          take, room2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.magic_word         <= '0;
      cfg_r.required_version   <= 16'd256;
      cfg_r.encoding_limit     <= 8'd8;
      cfg_r.format_limit       <= 8'd16;
      cfg_r.custom_format_code <= 8'd15;
      cfg_r.palette_flag_bit   <= 8'd1;
      cfg_r.masks_flag_bit     <= 8'd2;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bcp_pkg::CFG_MAGIC:   cfg_r.magic_word         <= cfg_data;
        bcp_pkg::CFG_VERSION: cfg_r.required_version   <= cfg_data[15:0];
        bcp_pkg::CFG_ENC_LIM: cfg_r.encoding_limit     <= cfg_data[7:0];
        bcp_pkg::CFG_FMT_LIM: cfg_r.format_limit       <= cfg_data[7:0];
        bcp_pkg::CFG_CUSTOM:  cfg_r.custom_format_code <= cfg_data[7:0];
        bcp_pkg::CFG_PAL_BIT: cfg_r.palette_flag_bit   <= cfg_data[7:0];
        bcp_pkg::CFG_MSK_BIT: cfg_r.masks_flag_bit     <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  assign in_ready = room2;
  assign take     = in_valid && room2;

  bcp_core #(
    .PALETTE_MAX (PALETTE_MAX),
    .SIZE_BITS   (SIZE_BITS)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .take        (take),
    .file_byte   (in_file_byte),
    .end_of_file (in_end_of_file),
    .cfg         (cfg_r),
    .rec_n       (rec_n),
    .rec0        (rec0),
    .rec1        (rec1)
  );

  bcp_fifo #(
    .DEPTH (bcp_pkg::FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_n    (rec_n),
    .push_d0   (rec0),
    .push_d1   (rec1),
    .pop       (out_valid && out_ready),
    .head      (head),
    .not_empty (out_valid),
    .room2     (room2)
  );

  assign out_record_kind   = head.kind;
  assign out_record_index  = head.index;
  assign out_record_value  = head.value;
  assign out_status_code   = head.status;
  assign out_image_width   = head.width;
  assign out_image_height  = head.height;
  assign out_depth_bits    = head.depth;
  assign out_encoding_mode = head.encoding;
  assign out_format_code   = head.format;
  assign out_palette_size  = head.pal_size;
  assign out_run_last      = head.last;

endmodule

[src/bcp_checker.sv]
// Port-level assertions for the parser, bound to the top level.
module bcp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_record_kind,
  input logic [7:0]  out_record_index,
  input logic [31:0] out_record_value,
  input logic [3:0]  out_status_code,
  input logic [15:0] out_image_width,
  input logic [15:0] out_image_height,
  input logic [7:0]  out_depth_bits,
  input logic [7:0]  out_encoding_mode,
  input logic [7:0]  out_format_code,
  input logic [8:0]  out_palette_size,
  input logic        out_run_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result present after reset");

  a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_record_kind != 2'd3)
    else $error("illegal record kind");

  a_entry_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_record_kind != bcp_pkg::KIND_STATUS |->
      out_status_code == bcp_pkg::ST_OK && out_image_width == 16'd0 &&
      out_image_height == 16'd0 && out_depth_bits == 8'd0 &&
      out_encoding_mode == 8'd0 && out_format_code == 8'd0 &&
      out_palette_size == 9'd0)
    else $error("entry record carries status fields");

  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_record_kind == bcp_pkg::KIND_STATUS |->
      out_run_last && out_record_index == 8'd0 && out_record_value == 32'd0)
    else $error("status record malformed");

endmodule

bind bitmap_container_header_parser bcp_checker u_bcp_checker (.*);
